@@ src/kmsd_pkg.sv @@
// Shared constants, types and register codes for the key matrix scanner.
package kmsd_pkg;

    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 4;
    localparam int LEVEL_W  = 8;
    localparam int KEY_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 4'd5;
    localparam logic [CFG_W-1:0] ROWS_RESET     = 4'd8;
    localparam logic [CFG_W-1:0] COLS_RESET     = 4'd8;
    localparam logic [CFG_W-1:0] ROWS_LIMIT     = 4'd8;
    localparam logic [CFG_W-1:0] COLS_LIMIT     = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE     = 2'd2;

    localparam logic EV_PRESS   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    typedef logic [MAX_COLS-1:0][CNT_W-1:0] t_cnt_row;

    typedef struct packed {
        logic [MAX_COLS-1:0] fire;
        logic [MAX_COLS-1:0] kind;
        logic [ROW_W-1:0]    row;
    } t_row_events;

endpackage

@@ src/kmsd_counters.sv @@
// Debounce counter bank: updates one row of counters per scan tick and flags edges.
module kmsd_counters (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_update,
    input  logic [kmsd_pkg::ROW_W-1:0]       i_row,
    input  logic [kmsd_pkg::LEVEL_W-1:0]     i_levels,
    input  logic [kmsd_pkg::CFG_W-1:0]       i_max,
    input  logic [kmsd_pkg::CFG_W-1:0]       i_ncols,
    output kmsd_pkg::t_row_events            o_events
);

    kmsd_pkg::t_cnt_row r_cnt [kmsd_pkg::MAX_ROWS];
    kmsd_pkg::t_cnt_row n_row;
    kmsd_pkg::t_cnt_row cur_row;

    assign cur_row = r_cnt[i_row];

    // Each column steps independently; columns beyond the count in use hold.
    always_comb begin
        n_row         = cur_row;
        o_events.fire = '0;
        o_events.kind = '0;
        o_events.row  = i_row;
        for (int c = 0; c < kmsd_pkg::MAX_COLS; c++) begin
            if (c[kmsd_pkg::CFG_W-1:0] < i_ncols) begin
                if (!i_levels[c]) begin
                    if (cur_row[c] < i_max) begin
                        n_row[c] = cur_row[c] + 4'd1;
                        if (n_row[c] == i_max) begin
                            o_events.fire[c] = 1'b1;
                            o_events.kind[c] = kmsd_pkg::EV_PRESS;
                        end
                    end
                end else if (cur_row[c] != '0) begin
                    n_row[c] = cur_row[c] - 4'd1;
                    if (n_row[c] == '0) begin
                        o_events.fire[c] = 1'b1;
                        o_events.kind[c] = kmsd_pkg::EV_RELEASE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < kmsd_pkg::MAX_ROWS; r++) begin
                r_cnt[r] <= '0;
            end
        end else if (i_update) begin
            r_cnt[i_row] <= n_row;
        end
    end

endmodule

@@ src/kmsd_emitter.sv @@
// Event emitter: holds one tick's event mask and sends events one beat at a time.
module kmsd_emitter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  kmsd_pkg::t_row_events            i_events,
    input  logic [kmsd_pkg::CFG_W-1:0]       i_ncols,
    output logic                             o_free,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_event_kind,
    output logic [kmsd_pkg::KEY_W-1:0]       o_key_code,
    output logic [kmsd_pkg::ROW_W-1:0]       o_row_index,
    output logic [kmsd_pkg::COL_W-1:0]       o_col_index,
    output logic                             o_last_event
);

    logic [kmsd_pkg::MAX_COLS-1:0] r_fire;
    logic [kmsd_pkg::MAX_COLS-1:0] r_kind;
    logic [kmsd_pkg::ROW_W-1:0]    r_row;
    logic                          r_out_valid;
    logic                          r_event_kind;
    logic [kmsd_pkg::KEY_W-1:0]    r_key_code;
    logic [kmsd_pkg::ROW_W-1:0]    r_row_index;
    logic [kmsd_pkg::COL_W-1:0]    r_col_index;
    logic                          r_last_event;

    logic [kmsd_pkg::COL_W-1:0]    sel;
    logic [kmsd_pkg::MAX_COLS-1:0] rest;
    logic                          out_open;
    logic                          out_load;
    logic [7:0]                    code_full;

    // Lowest pending column goes first.
    always_comb begin
        sel = '0;
        for (int c = kmsd_pkg::MAX_COLS - 1; c >= 0; c--) begin
            if (r_fire[c]) begin
                sel = c[kmsd_pkg::COL_W-1:0];
            end
        end
    end

    assign rest      = r_fire & ~(8'd1 << sel);
    assign out_open  = !r_out_valid || !i_stall;
    assign out_load  = out_open && (r_fire != '0);
    assign o_free    = (r_fire == '0) || (out_load && (rest == '0));
    assign code_full = ({5'd0, r_row} * {4'd0, i_ncols}) + {5'd0, sel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_fire <= i_events.fire;
            end else if (out_load) begin
                r_fire <= rest;
            end
            if (out_open) begin
                r_out_valid <= (r_fire != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_events.kind;
            r_row  <= i_events.row;
        end
        if (out_load) begin
            r_event_kind <= r_kind[sel];
            r_key_code   <= code_full[kmsd_pkg::KEY_W-1:0];
            r_row_index  <= r_row;
            r_col_index  <= sel;
            r_last_event <= (rest == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_event_kind;
    assign o_key_code   = r_key_code;
    assign o_row_index  = r_row_index;
    assign o_col_index  = r_col_index;
    assign o_last_event = r_last_event;

endmodule

@@ src/key_matrix_scan_debounce.sv @@
// Top level of the key matrix scanner with per-key integrating debounce.
//
// Usage: each beat on the input channel (i_valid, o_stall, i_col_levels) is one
// scan tick carrying the active-low column levels of the row currently driven.
// The block keeps a 4-bit debounce counter per key; a counter reaching the
// debounce maximum yields a press event and one falling to zero a release.
// Events leave on the output channel (o_valid, i_stall) one beat per cycle while
// the receiver does not stall, in column order, with o_last_event set on the
// final event of a tick. The first event of a tick passes through the input
// register, then the counter update into the event mask, then the output
// register. A tick yields at most eight events. The input register can take a
// new tick while the last one's events still go out; it enters the event mask
// once the last of those events is loaded into the output register.
// The row pointer advances when a tick is accepted and wraps at rows_in_use.
// Configuration writes (i_cfg_valid, o_cfg_ready, always ready) set
// press_threshold, rows_in_use and cols_in_use; they are expected while idle.
// Reset clears all counters, the row pointer and any pending events, and
// restores the register defaults (5, 8, 8). When the receiver stalls, the
// current event holds, the mask and input register fill, and o_stall rises.
module key_matrix_scan_debounce (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [kmsd_pkg::LEVEL_W-1:0]       i_col_levels,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_event_kind,
    output logic [kmsd_pkg::KEY_W-1:0]         o_key_code,
    output logic [kmsd_pkg::ROW_W-1:0]         o_row_index,
    output logic [kmsd_pkg::COL_W-1:0]         o_col_index,
    output logic                               o_last_event,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kmsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kmsd_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [kmsd_pkg::CFG_W-1:0]   r_press_threshold;
    logic [kmsd_pkg::CFG_W-1:0]   r_rows_in_use;
    logic [kmsd_pkg::CFG_W-1:0]   r_cols_in_use;
    logic [kmsd_pkg::ROW_W-1:0]   r_row_ptr;
    logic                         r_in_valid;
    logic [kmsd_pkg::LEVEL_W-1:0] r_in_levels;
    logic [kmsd_pkg::ROW_W-1:0]   r_in_row;

    logic [kmsd_pkg::CFG_W-1:0]   ncols;
    logic [kmsd_pkg::CFG_W-1:0]   nrows;
    logic [kmsd_pkg::CFG_W-1:0]   row_inc;
    logic [kmsd_pkg::ROW_W-1:0]   n_row_ptr;
    logic                         in_accept;
    logic                         emit_free;
    logic                         mask_load;
    kmsd_pkg::t_row_events        row_events;

    // Effective counts: requests beyond the matrix size are clipped.
    assign ncols = (r_cols_in_use > kmsd_pkg::COLS_LIMIT) ? kmsd_pkg::COLS_LIMIT : r_cols_in_use;
    assign nrows = (r_rows_in_use > kmsd_pkg::ROWS_LIMIT) ? kmsd_pkg::ROWS_LIMIT : r_rows_in_use;

    // The pointer wraps once the next row would reach the count in use; this
    // also returns to row zero when the count was lowered below the pointer.
    assign row_inc   = {1'b0, r_row_ptr} + 4'd1;
    assign n_row_ptr = (row_inc >= nrows) ? '0 : row_inc[kmsd_pkg::ROW_W-1:0];

    assign mask_load = r_in_valid && emit_free;
    assign o_stall   = r_in_valid && !emit_free;
    assign in_accept = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_threshold <= kmsd_pkg::DEBOUNCE_RESET;
            r_rows_in_use     <= kmsd_pkg::ROWS_RESET;
            r_cols_in_use     <= kmsd_pkg::COLS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kmsd_pkg::CFG_PRESS_THRESHOLD: r_press_threshold <= i_cfg_data;
                kmsd_pkg::CFG_ROWS_IN_USE:     r_rows_in_use     <= i_cfg_data;
                kmsd_pkg::CFG_COLS_IN_USE:     r_cols_in_use     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: holds one tick and the row it belongs to until the
    // event mask is free to take its update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_row_ptr  <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_row_ptr  <= n_row_ptr;
            end else if (mask_load) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_levels <= i_col_levels;
            r_in_row    <= r_row_ptr;
        end
    end

    kmsd_counters u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (mask_load),
        .i_row    (r_in_row),
        .i_levels (r_in_levels),
        .i_max    (r_press_threshold),
        .i_ncols  (ncols),
        .o_events (row_events)
    );

    kmsd_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (mask_load),
        .i_events     (row_events),
        .i_ncols      (ncols),
        .o_free       (emit_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_key_code   (o_key_code),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_last_event (o_last_event)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the key matrix scanner with per-key debounce.
module tb;

    // Percentage of ticks (input side) or cycles (receiver side) in which a side idles while idling is enabled.
    localparam int IDLE_PCT      = 7;
    // Length of the single long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES   = 200;
    // Cycles allowed after the last expected beat for ticks that emit nothing to drain.
    localparam int SETTLE_CYCLES = 16;
    // Hang limit, with ample margin over the slowest correct run.
    localparam int CYCLE_LIMIT   = 100000;
    // Index 3 addresses no register at all, so a write to it must be ignored.
    localparam logic [kmsd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One key event as it appears on the output channel.
    typedef struct packed {
        logic                       kind;
        logic [kmsd_pkg::KEY_W-1:0] code;
        logic [kmsd_pkg::ROW_W-1:0] row;
        logic [kmsd_pkg::COL_W-1:0] col;
        logic                       last;
    } t_key_event;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_valid      = 1'b0;
    logic                           o_stall;
    logic [kmsd_pkg::LEVEL_W-1:0]   i_col_levels = '1;
    logic                           o_valid;
    logic                           i_stall      = 1'b0;
    logic                           o_event_kind;
    logic [kmsd_pkg::KEY_W-1:0]     o_key_code;
    logic [kmsd_pkg::ROW_W-1:0]     o_row_index;
    logic [kmsd_pkg::COL_W-1:0]     o_col_index;
    logic                           o_last_event;
    logic                           i_cfg_valid  = 1'b0;
    logic                           o_cfg_ready;
    logic [kmsd_pkg::CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [kmsd_pkg::CFG_W-1:0]     i_cfg_data   = '0;

    key_matrix_scan_debounce u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_col_levels (i_col_levels),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_key_code   (o_key_code),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_last_event (o_last_event),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the scanner: its registers, its row pointer and every
    // debounce counter, advanced once for each accepted input beat.
    logic [kmsd_pkg::CFG_W-1:0] cfg_press_threshold;
    logic [kmsd_pkg::CFG_W-1:0] cfg_rows;
    logic [kmsd_pkg::CFG_W-1:0] cfg_cols;
    int                         exp_row_ptr;
    logic [kmsd_pkg::CNT_W-1:0] exp_counters [kmsd_pkg::MAX_ROWS][kmsd_pkg::MAX_COLS];

    // Events still owed by the block, oldest first.
    t_key_event pending_events [$];

    int   error_count  = 0;
    int   cycle_count  = 0;
    // While set, neither side idles at random.
    bit   quiet        = 1'b0;
    // Raised once by the back-pressure test; the stall process serves it.
    bit   hold_pending = 1'b0;
    bit   hold_served  = 1'b0;
    int   hold_left    = 0;

    // Keys currently held down, one byte per row, used to build realistic scans.
    logic [kmsd_pkg::LEVEL_W-1:0] held_keys [kmsd_pkg::MAX_ROWS];

    // Work out the events of one scan tick and advance the shadow state.
    task automatic predict_scan_tick(input logic [kmsd_pkg::LEVEL_W-1:0] levels);
        int                         ncols;
        int                         nrows;
        int                         row;
        int                         n;
        int                         code;
        logic [kmsd_pkg::CNT_W-1:0] cnt;
        bit                         fire;
        logic                       kind;
        t_key_event                 evs [kmsd_pkg::MAX_COLS];
        ncols = cfg_cols;
        nrows = cfg_rows;
        row   = exp_row_ptr;
        n     = 0;
        kind  = kmsd_pkg::EV_PRESS;
        // An oversized column or row count is clipped to the matrix size.
        if (ncols > kmsd_pkg::MAX_COLS) ncols = kmsd_pkg::MAX_COLS;
        if (ncols > kmsd_pkg::LEVEL_W) ncols = kmsd_pkg::LEVEL_W;
        if (nrows > kmsd_pkg::MAX_ROWS) nrows = kmsd_pkg::MAX_ROWS;
        if (row >= kmsd_pkg::MAX_ROWS) row = 0;
        for (int col = 0; col < ncols; col++) begin
            cnt  = exp_counters[row][col];
            fire = 1'b0;
            if (levels[col] == 1'b0) begin
                // A counter above a lowered maximum simply stays put on a low level.
                if (cnt < cfg_press_threshold) begin
                    cnt = cnt + 1'b1;
                    if (cnt == cfg_press_threshold) begin
                        fire = 1'b1;
                        kind = kmsd_pkg::EV_PRESS;
                    end
                end
            end else if (cnt != '0) begin
                cnt = cnt - 1'b1;
                if (cnt == '0) begin
                    fire = 1'b1;
                    kind = kmsd_pkg::EV_RELEASE;
                end
            end
            exp_counters[row][col] = cnt;
            if (fire) begin
                code        = (row * ncols + col) & 63;
                evs[n].kind = kind;
                evs[n].code = code[kmsd_pkg::KEY_W-1:0];
                evs[n].row  = row[kmsd_pkg::ROW_W-1:0];
                evs[n].col  = col[kmsd_pkg::COL_W-1:0];
                evs[n].last = 1'b0;
                n++;
            end
        end
        if (n > 0) evs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_events.push_back(evs[i]);
        // A row count of zero, or one lowered below the pointer, sends it back to row 0.
        row++;
        if (row >= nrows) row = 0;
        exp_row_ptr = row;
    endtask

    // Offer one scan tick, possibly after a short idle gap, and hold it until accepted.
    task automatic scan_tick(input logic [kmsd_pkg::LEVEL_W-1:0] levels);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_col_levels <= levels;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_scan_tick(levels);
    endtask

    // Stop offering beats, wait for every owed event, then let silent ticks drain.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One beat on the configuration channel, mirrored into the shadow registers.
    task automatic write_reg(input logic [kmsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kmsd_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            kmsd_pkg::CFG_PRESS_THRESHOLD: begin
                cfg_press_threshold = data;
            end
            kmsd_pkg::CFG_ROWS_IN_USE: begin
                cfg_rows = data;
            end
            kmsd_pkg::CFG_COLS_IN_USE: begin
                cfg_cols = data;
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reprogram all three registers once the block has gone idle.
    task automatic load_config(input logic [kmsd_pkg::CFG_W-1:0] max_deb,
                               input logic [kmsd_pkg::CFG_W-1:0] rows,
                               input logic [kmsd_pkg::CFG_W-1:0] cols);
        wait_quiet();
        write_reg(kmsd_pkg::CFG_PRESS_THRESHOLD, max_deb);
        write_reg(kmsd_pkg::CFG_ROWS_IN_USE, rows);
        write_reg(kmsd_pkg::CFG_COLS_IN_USE, cols);
    endtask

    // A whole row pressing and releasing at once gives the longest burst of events.
    task automatic test_full_row();
        load_config(4'd1, 4'd1, 4'd8);
        scan_tick(8'h00);
        scan_tick(8'hFF);
        scan_tick(8'hA5);
        scan_tick(8'hFF);
    endtask

    // Integration up to the maximum, then a lowered maximum, then a maximum of zero.
    task automatic test_debounce_limits();
        load_config(4'd3, 4'd1, 4'd2);
        repeat (3) scan_tick(8'hFC);
        // The counters now sit at 3, above the new maximum of 1.
        load_config(4'd1, 4'd1, 4'd2);
        scan_tick(8'hFC);
        repeat (3) scan_tick(8'hFF);
        // With a maximum of zero nothing can ever be pressed.
        load_config(4'd0, 4'd1, 4'd2);
        scan_tick(8'h00);
        scan_tick(8'hFF);
    endtask

    // Zero columns, an oversized column count and a write to the unused index.
    task automatic test_columns();
        load_config(4'd1, 4'd2, 4'd0);
        scan_tick(8'h00);
        load_config(4'd1, 4'd2, 4'd15);
        write_reg(CFG_UNUSED, 4'hF);
        scan_tick(8'h00);
        scan_tick(8'h00);
        scan_tick(8'hFF);
        scan_tick(8'hFF);
    endtask

    // Zero rows, an oversized row count and a row count lowered below the pointer.
    task automatic test_rows();
        load_config(4'd1, 4'd0, 4'd8);
        scan_tick(8'h7F);
        scan_tick(8'hFF);
        load_config(4'd1, 4'd15, 4'd8);
        while (exp_row_ptr != 5) scan_tick(8'hFF);
        load_config(4'd1, 4'd2, 4'd8);
        scan_tick(8'h00);
        scan_tick(8'hFF);
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so the
    // block fills up and stalls its input.
    task automatic test_back_pressure();
        load_config(4'd1, 4'd1, 4'd8);
        hold_pending = 1'b1;
        for (int i = 0; i < 30; i++) scan_tick((i % 2 == 0) ? 8'h00 : 8'hFF);
    endtask

    // One phase of realistic scanning: mostly held keys with the odd bounce,
    // plus some purely random rows.
    task automatic run_phase(input logic [kmsd_pkg::CFG_W-1:0] max_deb,
                             input logic [kmsd_pkg::CFG_W-1:0] rows,
                             input logic [kmsd_pkg::CFG_W-1:0] cols, input int n_ticks);
        logic [kmsd_pkg::LEVEL_W-1:0] levels;
        int                           b;
        load_config(max_deb, rows, cols);
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 99) < 20) begin
                levels = 8'($urandom_range(0, 255));
            end else begin
                if ($urandom_range(0, 11) == 0) begin
                    b = $urandom_range(0, kmsd_pkg::LEVEL_W - 1);
                    held_keys[exp_row_ptr][b] = ~held_keys[exp_row_ptr][b];
                end
                levels = ~held_keys[exp_row_ptr];
                if ($urandom_range(0, 9) == 0) begin
                    b = $urandom_range(0, kmsd_pkg::LEVEL_W - 1);
                    levels[b] = ~levels[b];
                end
            end
            scan_tick(levels);
        end
    endtask

    task automatic test_random_scan();
        for (int r = 0; r < kmsd_pkg::MAX_ROWS; r++) begin
            held_keys[r] = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
        end
        run_phase(4'd5, 4'd8, 4'd8, 60);
        run_phase(4'd1, 4'd3, 4'd5, 50);
        run_phase(4'd15, 4'd1, 4'd8, 50);
        // A long stretch with no idling on either side.
        quiet = 1'b1;
        run_phase(4'd2, 4'd2, 4'd8, 50);
        quiet = 1'b0;
        run_phase(4'd0, 4'd4, 4'd4, 40);
        run_phase(4'd3, 4'd15, 4'd15, 50);
        run_phase(4'd4, 4'd0, 4'd8, 40);
        run_phase(4'd7, 4'd8, 4'd3, 50);
        run_phase(4'($urandom_range(1, 15)), 4'($urandom_range(1, 8)),
                  4'($urandom_range(1, 8)), 25);
    endtask

    // Receiver side: random stalls, plus the one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_pending && !hold_served) begin
            i_stall     <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Every accepted output beat is matched against the oldest owed event.
    always @(posedge i_clk) begin : check_events
        t_key_event want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: key_code %0d row %0d col %0d",
                       o_key_code, o_row_index, o_col_index);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", int'(want.kind), int'(o_event_kind));
                check_field("key_code", int'(want.code), int'(o_key_code));
                check_field("row_index", int'(want.row), int'(o_row_index));
                check_field("col_index", int'(want.col), int'(o_col_index));
                check_field("last_event", int'(want.last), int'(o_last_event));
            end
        end
    end

    // Guard against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        // The shadow state starts from the reset values of the block.
        cfg_press_threshold = kmsd_pkg::DEBOUNCE_RESET;
        cfg_rows            = kmsd_pkg::ROWS_RESET;
        cfg_cols            = kmsd_pkg::COLS_RESET;
        exp_row_ptr         = 0;
        for (int r = 0; r < kmsd_pkg::MAX_ROWS; r++)
            for (int c = 0; c < kmsd_pkg::MAX_COLS; c++) exp_counters[r][c] = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_full_row();
        test_debounce_limits();
        test_columns();
        test_rows();
        test_back_pressure();
        test_random_scan();

        wait_quiet();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
